// ===== design/kce_pkg.sv =====
package kce_pkg;

  // Default and limit of the per-operand digit count
  localparam int unsigned MaxDigitsDef = 5;

  // Operands are non-negative and never exceed 32767, so 15 bits hold them
  localparam int unsigned OpW   = 15;
  localparam int unsigned StepW = $clog2(OpW);
  localparam int unsigned ValW  = 16;

  // Largest operand, and the digit accumulation width (operand*10 + 9)
  localparam int unsigned OperandLimit = 32767;
  localparam int unsigned AccW         = OpW + 4;
  localparam int unsigned MaxDigitVal  = 9;

  // Key codes
  localparam logic [2:0] FuncDigit = 3'd0;
  localparam logic [2:0] FuncAdd   = 3'd1;
  localparam logic [2:0] FuncSub   = 3'd2;
  localparam logic [2:0] FuncMul   = 3'd3;
  localparam logic [2:0] FuncDiv   = 3'd4;
  localparam logic [2:0] FuncEq    = 3'd5;

  // Result status codes
  localparam logic [1:0] StatAccept = 2'd0;
  localparam logic [1:0] StatResult = 2'd1;
  localparam logic [1:0] StatError  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_EMIT = 2'd3
  } state_e;

endpackage

// ===== design/keypad_calculator_entry.sv =====
// Four-function integer calculator fed one key per transfer.
// Input channel: in_valid_i/in_ready_o with func_i (0 digit, 1..4 add, sub,
// mul, div, 5 equals) and digit_i. Output channel: out_valid_o/out_ready_i
// with status_o (0 accepted, 1 result, 2 error), value_o and error_flag_o.
// Every key gives exactly one output transfer.
// Digits, operators, add, subtract and every error go from the input
// transfer through the result stage to the output register. Multiply and
// divide first run a shared 30-bit shift register one operand bit per
// cycle. A new key is taken only once the last result has left the
// result stage for the output register.
// The output register parts the two sides: the next key is taken while a
// result still waits. If the receiver stalls, the following result is held
// in the result stage and no further key is taken until it moves on.
// Reset clears both operands, the digit count, the operator (add), the
// error level and all handshake state; the block is ready at once.
module keypad_calculator_entry #(
  parameter int unsigned MAX_DIGITS = kce_pkg::MaxDigitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        func_i,
  input  logic [3:0]                        digit_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [kce_pkg::ValW-1:0]   value_o,
  output logic                              error_flag_o
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned OpW  = kce_pkg::OpW;
  localparam int unsigned AccW = kce_pkg::AccW;
  localparam int unsigned ValW = kce_pkg::ValW;
  localparam int unsigned StepW = kce_pkg::StepW;

  kce_pkg::state_e state_q, state_d;
  kce_pkg::op_e    op_q, op_d;

  logic [OpW-1:0]   first_q, first_d;
  logic [OpW-1:0]   second_q, second_d;
  logic             on_second_q, on_second_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             err_q, err_d;

  // Shared multiply/divide shift register: upper half is the partial
  // product or remainder, lower half the multiplier or dividend/quotient
  logic [OpW-1:0]   hi_q, hi_d;
  logic [OpW-1:0]   lo_q, lo_d;
  logic [StepW-1:0] step_q, step_d;

  // Result waiting for the output register
  logic [1:0]       res_stat_q, res_stat_d;
  logic [ValW-1:0]  res_val_q, res_val_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_stat_q, out_stat_d;
  logic [ValW-1:0]  out_val_q, out_val_d;
  logic             out_err_q, out_err_d;

  logic             in_accept;
  logic             out_free;
  logic             last_step;
  logic [OpW-1:0]   cur_operand;
  logic [AccW-1:0]  acc_val;
  logic [OpW:0]     add_sum;
  logic [OpW:0]     mul_sum;
  logic [OpW:0]     div_trial;
  logic             div_fit;
  logic             is_equals_mul;
  logic             is_equals_div;

  assign in_ready_o  = (state_q == kce_pkg::ST_IDLE);
  assign in_accept   = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign last_step   = (step_q == StepW'(OpW - 1));

  assign cur_operand = on_second_q ? second_q : first_q;
  // operand * 10 + digit as two shifted adds
  assign acc_val     = (AccW'(cur_operand) << 3) + (AccW'(cur_operand) << 1)
                     + AccW'(digit_i);
  assign add_sum     = {1'b0, first_q} + {1'b0, second_q};

  // One multiplier bit per step: add multiplicand when the low bit is set
  assign mul_sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, first_q} : '0);
  // One quotient bit per step: shift in the next dividend bit and trial subtract
  assign div_trial   = {hi_q, lo_q[OpW-1]};
  assign div_fit     = (div_trial >= {1'b0, second_q});

  assign is_equals_mul = (func_i == kce_pkg::FuncEq) && on_second_q
                       && (op_q == kce_pkg::OP_MUL);
  assign is_equals_div = (func_i == kce_pkg::FuncEq) && on_second_q
                       && (op_q == kce_pkg::OP_DIV) && (second_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kce_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (is_equals_mul) begin
            state_d = kce_pkg::ST_MUL;
          end else if (is_equals_div) begin
            state_d = kce_pkg::ST_DIV;
          end else begin
            state_d = kce_pkg::ST_EMIT;
          end
        end
      end
      kce_pkg::ST_MUL, kce_pkg::ST_DIV: begin
        if (last_step) begin
          state_d = kce_pkg::ST_EMIT;
        end
      end
      kce_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = kce_pkg::ST_IDLE;
        end
      end
      default: state_d = kce_pkg::ST_IDLE;
    endcase
  end

  // Datapath and entry state
  always_comb begin
    first_d     = first_q;
    second_d    = second_q;
    on_second_d = on_second_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    err_d       = err_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    step_d      = step_q;
    res_stat_d  = res_stat_q;
    res_val_d   = res_val_q;

    case (state_q)
      kce_pkg::ST_IDLE: begin
        if (in_accept) begin
          res_stat_d = kce_pkg::StatError;
          res_val_d  = '0;
          step_d     = '0;
          case (func_i)
            kce_pkg::FuncDigit: begin
              if (digit_i > 4'(kce_pkg::MaxDigitVal) || cnt_q >= CntW'(MAX_DIGITS)
                  || acc_val > AccW'(kce_pkg::OperandLimit)) begin
                err_d = 1'b1;
              end else begin
                err_d      = 1'b0;
                cnt_d      = CntW'(cnt_q + 1'b1);
                res_stat_d = kce_pkg::StatAccept;
                if (on_second_q) begin
                  second_d = acc_val[OpW-1:0];
                end else begin
                  first_d = acc_val[OpW-1:0];
                end
              end
            end
            kce_pkg::FuncAdd, kce_pkg::FuncSub, kce_pkg::FuncMul, kce_pkg::FuncDiv: begin
              if (on_second_q) begin
                err_d = 1'b1;
              end else begin
                cnt_d       = '0;
                on_second_d = 1'b1;
                op_d        = kce_pkg::op_e'(2'(func_i - kce_pkg::FuncAdd));
                res_stat_d  = kce_pkg::StatAccept;
              end
            end
            kce_pkg::FuncEq: begin
              if (!on_second_q) begin
                err_d = 1'b1;
              end else begin
                case (op_q)
                  kce_pkg::OP_ADD: begin
                    if (add_sum[OpW]) begin
                      err_d = 1'b1;
                    end else begin
                      res_stat_d = kce_pkg::StatResult;
                      res_val_d  = ValW'(add_sum);
                    end
                  end
                  kce_pkg::OP_SUB: begin
                    res_stat_d = kce_pkg::StatResult;
                    res_val_d  = {1'b0, first_q} - {1'b0, second_q};
                  end
                  kce_pkg::OP_MUL: begin
                    hi_d = '0;
                    lo_d = second_q;
                  end
                  default: begin
                    if (second_q == '0) begin
                      err_d = 1'b1;
                    end else begin
                      hi_d = '0;
                      lo_d = first_q;
                    end
                  end
                endcase
              end
            end
            default: err_d = 1'b1;
          endcase
          // Clear the entry on any error and after an add or subtract result
          if (err_d && (res_stat_d == kce_pkg::StatError)) begin
            first_d     = '0;
            second_d    = '0;
            on_second_d = 1'b0;
            cnt_d       = '0;
          end else if (res_stat_d == kce_pkg::StatResult) begin
            first_d     = '0;
            second_d    = '0;
            on_second_d = 1'b0;
            cnt_d       = '0;
          end
        end
      end
      kce_pkg::ST_MUL: begin
        hi_d   = mul_sum[OpW:1];
        lo_d   = {mul_sum[0], lo_q[OpW-1:1]};
        step_d = StepW'(step_q + 1'b1);
        if (last_step) begin
          if (mul_sum[OpW:1] != '0) begin
            err_d      = 1'b1;
            res_stat_d = kce_pkg::StatError;
            res_val_d  = '0;
          end else begin
            res_stat_d = kce_pkg::StatResult;
            res_val_d  = {1'b0, mul_sum[0], lo_q[OpW-1:1]};
          end
          first_d     = '0;
          second_d    = '0;
          on_second_d = 1'b0;
          cnt_d       = '0;
        end
      end
      kce_pkg::ST_DIV: begin
        hi_d   = div_fit ? OpW'(div_trial - {1'b0, second_q}) : div_trial[OpW-1:0];
        lo_d   = {lo_q[OpW-2:0], div_fit};
        step_d = StepW'(step_q + 1'b1);
        if (last_step) begin
          res_stat_d  = kce_pkg::StatResult;
          res_val_d   = {1'b0, lo_q[OpW-2:0], div_fit};
          first_d     = '0;
          second_d    = '0;
          on_second_d = 1'b0;
          cnt_d       = '0;
        end
      end
      default: ;
    endcase
  end

  // Output register: load from the result stage once the slot is free
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;
    if (state_q == kce_pkg::ST_EMIT && out_free) begin
      out_valid_d = 1'b1;
      out_stat_d  = res_stat_q;
      out_val_d   = res_val_q;
      out_err_d   = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kce_pkg::ST_IDLE;
      op_q        <= kce_pkg::OP_ADD;
      first_q     <= '0;
      second_q    <= '0;
      on_second_q <= 1'b0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      first_q     <= first_d;
      second_q    <= second_d;
      on_second_q <= on_second_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    res_stat_q <= res_stat_d;
    res_val_q  <= res_val_d;
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_stat_q;
  assign value_o      = out_val_q;
  assign error_flag_o = out_err_q;

  // A value only travels with a computed result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != kce_pkg::StatResult) |-> (value_o == '0))
    else $error("nonzero value on a non-result transfer");

  // An error transfer always carries the raised error level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == kce_pkg::StatError) |-> error_flag_o)
    else $error("error transfer without error flag");

  // Digit count never passes its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DIGITS))
    else $error("digit count beyond limit");

  // A taken key always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != kce_pkg::ST_IDLE))
    else $error("key taken without leaving idle");

endmodule

// ===== sim/tb_keypad_calculator_entry.sv =====
`timescale 1ns / 1ps

module tb_keypad_calculator_entry;

  // Ceiling on the whole run. The slowest legal key is a multiply or divide,
  // and long sender gaps and receiver stalls add to it, so the limit leaves
  // ample room for roughly a thousand keys.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseKeys  = 235;
  localparam int unsigned DrainWait  = 40;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] value;
    logic               error_flag;
  } key_resp_t;

  // One directed key. The response is typed in only where it is obvious;
  // other rows take the calculator prediction.
  typedef struct packed {
    logic [2:0] func;
    logic [3:0] digit;
    logic       fixed;
    key_resp_t  resp;
  } key_row_t;

  localparam key_resp_t NoResp  = '0;
  localparam key_resp_t ErrResp =
    '{status: kce_pkg::StatError, value: 16'sd0, error_flag: 1'b1};
  localparam key_resp_t MaxResp =
    '{status: kce_pkg::StatResult, value: 16'sd32767, error_flag: 1'b0};

  localparam int unsigned NumDirected = 33;
  localparam key_row_t DirectedKeys [NumDirected] = '{
    // equals before any operator, digit above nine, the two unused key codes
    '{kce_pkg::FuncEq,    4'd0,  1'b1, ErrResp},
    '{kce_pkg::FuncDigit, 4'd15, 1'b1, ErrResp},
    '{3'd6,               4'd0,  1'b1, ErrResp},
    '{3'd7,               4'd9,  1'b1, ErrResp},
    // largest operand, then one digit too many
    '{kce_pkg::FuncDigit, 4'd3,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd2,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd7,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd6,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd7,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd0,  1'b1, ErrResp},
    // five digits that go past the operand limit
    '{kce_pkg::FuncDigit, 4'd4,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd0,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd0,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd0,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd0,  1'b1, ErrResp},
    // operator with no digits, then a second operator
    '{kce_pkg::FuncSub,   4'd0,  1'b0, NoResp},
    '{kce_pkg::FuncAdd,   4'd8,  1'b1, ErrResp},
    // divide with an empty second operand
    '{kce_pkg::FuncDiv,   4'd0,  1'b0, NoResp},
    '{kce_pkg::FuncEq,    4'd0,  1'b1, ErrResp},
    // 9 * 9999 leaves the int16 range
    '{kce_pkg::FuncDigit, 4'd9,  1'b0, NoResp},
    '{kce_pkg::FuncMul,   4'd0,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd9,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd9,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd9,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd9,  1'b0, NoResp},
    '{kce_pkg::FuncEq,    4'd0,  1'b1, ErrResp},
    // 0 + 32767 gives the largest result
    '{kce_pkg::FuncAdd,   4'd0,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd3,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd2,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd7,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd6,  1'b0, NoResp},
    '{kce_pkg::FuncDigit, 4'd7,  1'b0, NoResp},
    '{kce_pkg::FuncEq,    4'd0,  1'b1, MaxResp}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [2:0]                      func_i;
  logic [3:0]                      digit_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [1:0]                      status_o;
  logic signed [kce_pkg::ValW-1:0] value_o;
  logic                            error_flag_o;

  keypad_calculator_entry dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .digit_i      (digit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .value_o      (value_o),
    .error_flag_o (error_flag_o)
  );

  // Calculator state as the testbench tracks it
  logic [kce_pkg::OpW-1:0] lhs_opnd;
  logic [kce_pkg::OpW-1:0] rhs_opnd;
  logic                    on_rhs;
  int unsigned             digits_in;
  kce_pkg::op_e            pending_op;
  logic                    err_level;

  key_resp_t   key_resp_q [$];
  int unsigned fail_cnt = 0;
  int unsigned keys_sent;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  // Work out the response to one key and advance the tracked state.
  function automatic key_resp_t calc_key_response(logic [2:0] func, logic [3:0] digit);
    key_resp_t   resp;
    int unsigned acc;
    int          lhs;
    int          rhs;
    int          res;
    logic        fault;
    fault = 1'b0;
    res   = 0;
    resp  = NoResp;
    resp.status = kce_pkg::StatAccept;
    case (func)
      kce_pkg::FuncDigit: begin
        if (digit > kce_pkg::MaxDigitVal || digits_in >= kce_pkg::MaxDigitsDef) begin
          fault = 1'b1;
        end else begin
          // A valid digit clears the error level even if it then overflows
          err_level = 1'b0;
          digits_in++;
          acc = (on_rhs ? rhs_opnd : lhs_opnd) * 10 + digit;
          if (acc > kce_pkg::OperandLimit) begin
            fault = 1'b1;
          end else if (on_rhs) begin
            rhs_opnd = acc[kce_pkg::OpW-1:0];
          end else begin
            lhs_opnd = acc[kce_pkg::OpW-1:0];
          end
        end
      end
      kce_pkg::FuncAdd, kce_pkg::FuncSub, kce_pkg::FuncMul, kce_pkg::FuncDiv: begin
        if (on_rhs) begin
          fault = 1'b1;
        end else begin
          digits_in  = 0;
          on_rhs     = 1'b1;
          pending_op = kce_pkg::op_e'(func[1:0] - 2'd1);
        end
      end
      kce_pkg::FuncEq: begin
        if (!on_rhs) begin
          fault = 1'b1;
        end else begin
          lhs = int'(lhs_opnd);
          rhs = int'(rhs_opnd);
          case (pending_op)
            kce_pkg::OP_ADD: res = lhs + rhs;
            kce_pkg::OP_SUB: res = lhs - rhs;
            kce_pkg::OP_MUL: res = lhs * rhs;
            default: begin
              if (rhs == 0) begin
                fault = 1'b1;
              end else begin
                res = lhs / rhs;
              end
            end
          endcase
          if (!fault && (res < -32768 || res > 32767)) begin
            fault = 1'b1;
          end
          if (!fault) begin
            resp.status = kce_pkg::StatResult;
            resp.value  = res[15:0];
          end
        end
      end
      default: fault = 1'b1;
    endcase
    if (fault) begin
      err_level   = 1'b1;
      resp.status = kce_pkg::StatError;
      resp.value  = 16'sd0;
    end
    // Both a fault and a finished equals clear the entry
    if (fault || resp.status == kce_pkg::StatResult) begin
      lhs_opnd  = '0;
      rhs_opnd  = '0;
      on_rhs    = 1'b0;
      digits_in = 0;
    end
    resp.error_flag = err_level;
    return resp;
  endfunction

  // Present one key, hold it until the transfer, and queue its response.
  // Valid is lowered only during a gap, so back-to-back keys keep it high.
  task automatic send_key(logic [2:0] func, logic [3:0] digit, logic fixed, key_resp_t fixed_resp);
    key_resp_t resp;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    digit_i    <= digit;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    resp = calc_key_response(func, digit);
    key_resp_q.push_back(fixed ? fixed_resp : resp);
    keys_sent++;
  endtask

  task automatic send_digits(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_key(kce_pkg::FuncDigit, 4'($urandom_range(0, 9)), 1'b0, NoResp);
    end
  endtask

  // Mostly short operands so that multiply results stay in range;
  // now and then five digits, or six, which is one too many.
  function automatic int unsigned pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
  endfunction

  // One well-formed expression with random content: digits, operator,
  // digits, equals. The digit field of non-digit keys carries noise.
  task automatic send_expression();
    send_digits(pick_len());
    send_key(3'($urandom_range(kce_pkg::FuncAdd, kce_pkg::FuncDiv)),
             4'($urandom_range(0, 15)), 1'b0, NoResp);
    send_digits(pick_len());
    send_key(kce_pkg::FuncEq, 4'($urandom_range(0, 15)), 1'b0, NoResp);
  endtask

  // Hold off the sender until every queued response has come back
  task automatic drain_responses();
    in_valid_i <= 1'b0;
    while (key_resp_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall at the rate of the current phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each response transfer with the oldest queued expectation
  always @(posedge clk_i) begin : check_response
    key_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (key_resp_q.size() == 0) begin
        $error("response with none expected: status %0d value %0d error_flag %0d",
               status_o, value_o, error_flag_o);
        fail_cnt++;
      end else begin
        want = key_resp_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_cnt++;
        end
        if (value_o !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, value_o);
          fail_cnt++;
        end
        if (error_flag_o !== want.error_flag) begin
          $error("error_flag: expected %0d, got %0d", want.error_flag, error_flag_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("[keypad_calculator_entry] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = kce_pkg::FuncDigit;
    digit_i     = 4'd0;
    out_ready_i = 1'b0;
    keys_sent   = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    lhs_opnd    = '0;
    rhs_opnd    = '0;
    on_rhs      = 1'b0;
    digits_in   = 0;
    pending_op  = kce_pkg::OP_ADD;
    err_level   = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed keys: edges of every field and the fault cases other than add overflow
    for (int unsigned i = 0; i < NumDirected; i++) begin
      send_key(DirectedKeys[i].func, DirectedKeys[i].digit,
               DirectedKeys[i].fixed, DirectedKeys[i].resp);
    end
    drain_responses();

    // Random phases: no idling, sender gaps, receiver stalls, then both
    for (int phase = 0; phase < 4; phase++) begin
      int unsigned target;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 74; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      target = keys_sent + PhaseKeys;
      while (keys_sent < target) begin
        if ($urandom_range(0, 99) < 80) begin
          send_expression();
        end else begin
          // Noise: any key code, any digit value, broken sequences
          repeat ($urandom_range(1, 3)) begin
            send_key(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 1'b0, NoResp);
          end
        end
      end
      drain_responses();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0 && key_resp_q.size() == 0) begin
      $display("[keypad_calculator_entry] OK");
    end else begin
      $display("[keypad_calculator_entry] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kce_pkg.sv
design/keypad_calculator_entry.sv
sim/tb_keypad_calculator_entry.sv
